FILE: rtl/nmhm_pkg.sv
// nmhm_pkg: shared types and constants for the nibble map heap manager.
// No dependencies.
package nmhm_pkg;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [15:0] addr;
        logic [10:0] length;
        logic [3:0]  owner;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] value;
    } t_rsp;

    localparam logic [3:0] OP_OWNER  = 4'd0;
    localparam logic [3:0] OP_SIZE   = 4'd1;
    localparam logic [3:0] OP_FREE   = 4'd2;
    localparam logic [3:0] OP_CLAIM  = 4'd3;
    localparam logic [3:0] OP_ROPEN  = 4'd4;
    localparam logic [3:0] OP_WOPEN  = 4'd5;
    localparam logic [3:0] OP_CLOSE  = 4'd6;
    localparam logic [3:0] OP_SFREE  = 4'd7;
    localparam logic [3:0] OP_FPROC  = 4'd8;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_OWNER   = 3'd2;
    localparam logic [2:0] ST_NSHARED = 3'd3;
    localparam logic [2:0] ST_BUSY    = 3'd4;
    localparam logic [2:0] ST_CLOSED  = 3'd5;
    localparam logic [2:0] ST_NOROOM  = 3'd6;
    localparam logic [2:0] ST_ZEROLEN = 3'd7;

    localparam logic [3:0] NIB_FREE  = 4'h0;
    localparam logic [3:0] NIB_SH0   = 4'h8;
    localparam logic [3:0] NIB_SHMAX = 4'hC;
    localparam logic [3:0] NIB_WR    = 4'hE;
    localparam logic [3:0] NIB_CONT  = 4'hF;

    localparam logic [7:0] ADDR_USE_BASE = 8'h00;
    localparam logic [15:0] USE_BASE_RST = 16'd256;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEARW, S_BACKR, S_BACKW, S_HEADR, S_HEADW, S_FWDR, S_FWDW,
        S_CLMR, S_CLMW, S_CLMWR, S_FPR, S_FPW, S_DONE
    } t_state;

endpackage

FILE: rtl/nmhm_ram.sv
// nmhm_ram: generic single-port RAM, registered read.
// No dependencies.
module nmhm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/nibble_map_heap_manager.sv
// nibble_map_heap_manager: top level, sequencer and map walker.
// Depends on nmhm_pkg and nmhm_ram.
//
// Usage: one request enters on i_req_valid/o_req_stall; it carries an opcode,
// an absolute address, a claim length and an owner. Exactly one response
// leaves on o_rsp_valid/i_rsp_stall with a status and a value.
// The allocation map is a 4-bit-per-byte RAM with one port; a single
// sequencer walks it entry by entry (read, then decide/write).
// Simple ops scan back to the chunk head; free and size may also walk forward
// over the chunk bytes; claim checks each of its length entries, then
// writes them; free process sweeps the whole area and clears every chunk
// of its owner.
// Reset: a clearing pass writes zero to every map entry, with the request
// channel stalled; use_base returns to 256.
// While a request is in work, o_req_stall is high. A finished response sits
// in the output register until taken; a new request is accepted while it
// waits, and its response stalls until the old one leaves.
// APB writes of use_base must only be issued while the block is idle.
module nibble_map_heap_manager
    import nmhm_pkg::*;
#(
    parameter int USE_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(USE_SIZE);
    localparam int RW = AW + 1; // holds USE_SIZE itself

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [15:0] r_base;
    logic [RW-1:0] r_ptr, n_ptr;     // walk pointer
    logic [RW-1:0] r_head, n_head;
    logic [RW-1:0] r_rel, n_rel;
    logic [3:0]  r_h, n_h;
    logic [3:0]  r_relnib, n_relnib;
    logic [15:0] r_cnt, n_cnt;
    logic        r_fp, n_fp;         // clearing on behalf of free process
    logic [2:0]  r_st, n_st;
    logic [15:0] r_val, n_val;
    logic        r_ov, n_ov;
    t_rsp        r_rsp, n_rsp;

    logic          we;
    logic [AW-1:0] maddr;
    logic [3:0]    wdata, rdata;

    nmhm_ram #(.WIDTH(4), .DEPTH(USE_SIZE)) u_map (
        .i_clk(i_clk), .i_we(we), .i_addr(maddr), .i_wdata(wdata), .o_rdata(rdata)
    );

    assign pready = 1'b1;
    assign prdata = {16'd0, r_base};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= USE_BASE_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_USE_BASE[1:0]) begin
            r_base <= pwdata[15:0];
        end
    end

    logic [16:0] rel_full;
    logic        in_area;
    logic [RW:0] clm_end;
    assign rel_full = {1'b0, i_req.addr} - {1'b0, r_base};
    assign in_area  = !rel_full[16] && rel_full < 17'(USE_SIZE);
    assign clm_end  = (RW+1)'(r_rel) + (RW+1)'(r_req.length);

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_ov;
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEARW;
            r_ptr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_ov    <= n_ov;
        end
        r_req <= n_req; r_head <= n_head; r_rel <= n_rel; r_h <= n_h;
        r_relnib <= n_relnib; r_cnt <= n_cnt; r_fp <= n_fp;
        r_st <= n_st; r_val <= n_val; r_rsp <= n_rsp;
    end

    always_comb begin
        n_state = r_state; n_req = r_req; n_ptr = r_ptr; n_head = r_head;
        n_rel = r_rel; n_h = r_h; n_relnib = r_relnib; n_cnt = r_cnt;
        n_fp = r_fp; n_st = r_st; n_val = r_val; n_ov = r_ov; n_rsp = r_rsp;
        we = 1'b0; wdata = NIB_FREE; maddr = r_ptr[AW-1:0];
        if (r_ov && !i_rsp_stall) n_ov = 1'b0;
        unique case (r_state)
            S_CLEARW: begin // reset clearing pass
                we = 1'b1;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == RW'(USE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    n_st = ST_OK; n_val = '0; n_cnt = '0; n_fp = 1'b0;
                    n_rel = RW'(rel_full);
                    n_ptr = RW'(rel_full);
                    if (i_req.opcode > OP_FPROC) begin
                        n_st = ST_RANGE; n_state = S_DONE;
                    end else if (i_req.opcode == OP_FPROC) begin
                        n_ptr = '0;
                        if (i_req.owner == 4'd0 || i_req.owner > 4'd7) begin
                            n_st = ST_OWNER; n_state = S_DONE;
                        end else begin
                            n_state = S_FPR;
                        end
                    end else if (!in_area) begin
                        n_st = ST_RANGE; n_state = S_DONE;
                    end else if (i_req.opcode == OP_CLAIM) begin
                        n_state = S_CLMR;
                    end else begin
                        n_state = S_BACKR;
                    end
                end
            end
            S_BACKR: n_state = S_BACKW;
            S_BACKW: begin
                if (r_ptr == r_rel) n_relnib = rdata;
                if (r_ptr != '0 && rdata == NIB_CONT) begin
                    n_ptr = r_ptr - 1'b1; n_state = S_BACKR;
                end else begin
                    n_head = r_ptr; n_h = rdata; n_state = S_HEADR;
                end
            end
            S_HEADR: begin
                // decide on the head nibble; may write head, may start forward walk
                n_state = S_DONE;
                maddr = r_head[AW-1:0];
                case (r_req.opcode)
                    OP_OWNER: n_val = {12'd0, r_h};
                    OP_SIZE: begin
                        if (r_relnib == NIB_FREE) begin
                            n_val = '0;
                        end else begin
                            n_ptr = r_head + 1'b1; n_state = S_FWDR;
                        end
                    end
                    OP_FREE: begin
                        if (r_h == NIB_FREE || r_h > 4'd7 || r_h != r_req.owner) begin
                            n_st = ST_OWNER;
                        end else begin
                            n_val = r_base + 16'(r_head);
                            n_ptr = r_head; n_state = S_HEADW;
                        end
                    end
                    default: begin
                        if (r_h < NIB_SH0 || r_h == NIB_CONT) begin
                            n_st = ST_NSHARED;
                        end else if (r_req.opcode == OP_ROPEN) begin
                            if (r_h > NIB_SHMAX) n_st = ST_BUSY;
                            else begin
                                we = 1'b1; wdata = r_h + 4'd1;
                                n_val = r_base + 16'(r_head);
                            end
                        end else if (r_req.opcode == OP_WOPEN) begin
                            if (r_h != NIB_SH0) n_st = ST_BUSY;
                            else begin
                                we = 1'b1; wdata = NIB_WR; n_val = r_req.addr;
                            end
                        end else if (r_req.opcode == OP_CLOSE) begin
                            if (r_h < 4'd9) n_st = ST_CLOSED;
                            else begin
                                we = 1'b1;
                                wdata = (r_h == NIB_WR) ? NIB_SH0 : r_h - 4'd1;
                                n_val = r_base + 16'(r_head);
                            end
                        end else begin
                            if (r_h != NIB_SH0) n_st = ST_BUSY;
                            else begin
                                n_val = r_base + 16'(r_head);
                                n_ptr = r_head; n_state = S_HEADW;
                            end
                        end
                    end
                endcase
            end
            S_HEADW: begin // clear head, then walk continuation bytes
                we = 1'b1;
                n_ptr = r_ptr + 1'b1;
                n_state = (r_ptr + 1'b1 == RW'(USE_SIZE)) ? (r_fp ? S_FPR : S_DONE) : S_FWDR;
                if (r_fp && r_ptr + 1'b1 == RW'(USE_SIZE)) n_state = S_DONE;
            end
            S_FWDR: n_state = S_FWDW;
            S_FWDW: begin
                if (rdata == NIB_CONT) begin
                    if (r_req.opcode != OP_SIZE) we = 1'b1; // clearing
                    n_ptr = r_ptr + 1'b1;
                    n_state = (r_ptr + 1'b1 == RW'(USE_SIZE)) ? S_FWDW : S_FWDR;
                    if (r_ptr + 1'b1 == RW'(USE_SIZE)) n_state = r_fp ? S_DONE : S_DONE;
                    if (r_ptr + 1'b1 == RW'(USE_SIZE) && r_req.opcode == OP_SIZE)
                        n_val = 16'(RW'(USE_SIZE) - r_head);
                end else begin
                    if (r_req.opcode == OP_SIZE) begin
                        n_val = 16'(r_ptr - r_head); n_state = S_DONE;
                    end else if (r_fp) begin
                        n_state = S_FPR; // resume sweep at this entry
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLMR: begin
                if (r_req.length == '0) begin
                    n_st = ST_ZEROLEN; n_state = S_DONE;
                end else if (r_req.owner == 4'd0 || r_req.owner > 4'd8) begin
                    n_st = ST_OWNER; n_state = S_DONE;
                end else if (clm_end > (RW+1)'(USE_SIZE)) begin
                    n_st = ST_NOROOM; n_state = S_DONE;
                end else begin
                    n_state = S_CLMW;
                end
            end
            S_CLMW: begin
                if (rdata != NIB_FREE) begin
                    n_st = ST_NOROOM; n_state = S_DONE;
                end else if ((RW+1)'(r_ptr) + 1'b1 == clm_end) begin
                    n_ptr = r_rel; n_state = S_CLMWR;
                end else begin
                    n_ptr = r_ptr + 1'b1; n_state = S_CLMR;
                end
            end
            S_CLMWR: begin
                we = 1'b1;
                wdata = (r_ptr == r_rel) ? r_req.owner : NIB_CONT;
                n_ptr = r_ptr + 1'b1;
                if ((RW+1)'(r_ptr) + 1'b1 == clm_end) begin
                    n_val = r_req.addr; n_state = S_DONE;
                end
            end
            S_FPR: begin
                n_fp = 1'b1;
                if (r_ptr == RW'(USE_SIZE)) n_state = S_DONE;
                else n_state = S_FPW;
            end
            S_FPW: begin
                if (rdata == r_req.owner) begin
                    n_cnt = r_cnt + 1'b1; n_val = r_cnt + 1'b1;
                    n_head = r_ptr; n_state = S_HEADW;
                end else begin
                    n_ptr = r_ptr + 1'b1; n_state = S_FPR;
                end
            end
            S_DONE: begin
                if (!r_ov) begin
                    n_rsp.status = r_st;
                    n_rsp.value  = (r_st == ST_OK) ? r_val : 16'd0;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
